/* design/mln_pkg.sv */
// ----------------------------------------------------------------------------
// mln_pkg
// Shared constants, types and helpers of the Morton-code nearest lookup.
// ----------------------------------------------------------------------------
package mln_pkg;

  localparam int MAX_POINTS = 1024;
  localparam int AXIS_BITS  = 21;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = IDX_W + 1;
  localparam int CODE_W     = 3 * AXIS_BITS;
  localparam int COORD_W    = 32;

  localparam logic [AXIS_BITS-1:0] NORM_TOP = '1;

  localparam logic [1:0] AX_X = 2'd0;
  localparam logic [1:0] AX_Y = 2'd1;
  localparam logic [1:0] AX_Z = 2'd2;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_BUILD = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CRD_PREV  = 2'd0,
    CRD_FIRST = 2'd1,
    CRD_MID   = 2'd2
  } crd_sel_t;

  typedef enum logic [4:0] {
    S_IDLE, S_DECODE, S_B_RD, S_B_LATCH, S_N_START, S_N_WAIT, S_CODE,
    S_I_CHK, S_I_CMP, S_I_PUT, S_Q_INIT, S_Q_FIRST, S_Q_RD, S_Q_CMP,
    S_Q_UPD, S_Q_END, S_FINISH
  } ctrl_state_t;

  typedef enum logic [1:0] {
    N_IDLE, N_PREP, N_RUN
  } norm_state_t;

  typedef struct packed {
    logic     capture;
    logic     do_clear;
    logic     do_load;
    logic     i_clr;
    logic     pt_latch;
    logic     axis_clr;
    logic     norm_start;
    logic     norm_store;
    logic     code_load;
    crd_sel_t crd_sel;
    logic     ins_shift;
    logic     ins_put;
    logic     q_init;
    logic     q_first;
    logic     q_probe;
    logic     q_cmp;
    logic     q_upd;
    logic     set_res;
    status_t  res_status;
    logic     res_query;
    logic     out_load;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic cnt_zero;
    logic cnt_full;
    logic built;
    logic norm_done;
    logic axis_last;
    logic j_zero;
    logic shift_need;
    logic last_i;
    logic search_end;
    logic probe_eq;
    logic out_free;
  } sts_t;

  // x takes the top bit of each triple, then y, then z
  function automatic logic [CODE_W-1:0] interleave(input logic [AXIS_BITS-1:0] x,
                                                   input logic [AXIS_BITS-1:0] y,
                                                   input logic [AXIS_BITS-1:0] z);
    logic [CODE_W-1:0] c;
    c = '0;
    for (int k = 0; k < AXIS_BITS; k++) begin
      c[3*k+2] = x[k];
      c[3*k+1] = y[k];
      c[3*k]   = z[k];
    end
    return c;
  endfunction

endpackage

/* design/mln_if.sv */
// ----------------------------------------------------------------------------
// mln_in_if / mln_out_if
// Valid/ready channels for lookup commands and their results.
// ----------------------------------------------------------------------------
interface mln_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         op;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;

  modport source (output valid, op, pos_x, pos_y, pos_z, input ready);
  modport sink   (input valid, op, pos_x, pos_y, pos_z, output ready);
endinterface

interface mln_out_if;
  logic                       valid;
  logic                       ready;
  logic [mln_pkg::IDX_W-1:0]  nearest_index;
  logic                       exact_match;
  logic [mln_pkg::CODE_W-1:0] query_code;
  logic [1:0]                 status;

  modport source (output valid, nearest_index, exact_match, query_code, status,
                  input ready);
  modport sink   (input valid, nearest_index, exact_match, query_code, status,
                  output ready);
endinterface

/* design/mln_ram.sv */
// ----------------------------------------------------------------------------
// mln_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mln_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

/* design/mln_norm.sv */
// ----------------------------------------------------------------------------
// mln_norm
// Serial normalizer: floor((p - low) * 2^AXIS_BITS / span), clamped.
// ----------------------------------------------------------------------------
module mln_norm (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic signed [mln_pkg::COORD_W-1:0] p,
  input  logic signed [mln_pkg::COORD_W-1:0] low,
  input  logic signed [mln_pkg::COORD_W-1:0] high,
  output logic                             done,
  output logic [mln_pkg::AXIS_BITS-1:0]    q
);
  import mln_pkg::*;

  localparam int CB = $clog2(AXIS_BITS + 1);

  norm_state_t            state_r, state_nxt;
  logic                   done_r, done_nxt;
  logic signed [COORD_W:0] d_r;
  logic [COORD_W-1:0]     span_r;
  logic [COORD_W-1:0]     rem_r;
  logic [AXIS_BITS-1:0]   q_r;
  logic [CB-1:0]          cnt_r;
  logic                   zero_case;
  logic                   top_case;
  logic [COORD_W:0]       trial;

  assign zero_case = (span_r == '0) || d_r[COORD_W] || (d_r == '0);
  assign top_case  = d_r[COORD_W-1:0] >= span_r;
  assign trial     = {rem_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      N_IDLE: if (start) state_nxt = N_PREP;
      N_PREP: begin
        if (zero_case || top_case) begin
          state_nxt = N_IDLE;
          done_nxt  = 1'b1;
        end else begin
          state_nxt = N_RUN;
        end
      end
      N_RUN: begin
        if (cnt_r == CB'(1)) begin
          state_nxt = N_IDLE;
          done_nxt  = 1'b1;
        end
      end
      default: state_nxt = N_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      N_IDLE: begin
        if (start) begin
          d_r    <= {p[COORD_W-1], p} - {low[COORD_W-1], low};
          span_r <= high - low;
        end
      end
      N_PREP: begin
        cnt_r <= CB'(AXIS_BITS);
        rem_r <= d_r[COORD_W-1:0];
        if (zero_case) begin
          q_r <= '0;
        end else if (top_case) begin
          q_r <= NORM_TOP;
        end else begin
          q_r <= '0;
        end
      end
      N_RUN: begin
        // one quotient bit per cycle, remainder stays below span
        if (trial >= {1'b0, span_r}) begin
          rem_r <= COORD_W'(trial - {1'b0, span_r});
          q_r   <= {q_r[AXIS_BITS-2:0], 1'b1};
        end else begin
          rem_r <= trial[COORD_W-1:0];
          q_r   <= {q_r[AXIS_BITS-2:0], 1'b0};
        end
        cnt_r <= cnt_r - CB'(1);
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign q    = q_r;
endmodule

/* design/mln_dp.sv */
// ----------------------------------------------------------------------------
// mln_dp
// Datapath: point and table memories, bounds, normalizer, search registers.
// ----------------------------------------------------------------------------
module mln_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mln_pkg::cmd_t                    cmd,
  output mln_pkg::sts_t                    sts,
  input  logic [1:0]                       in_op,
  input  logic signed [mln_pkg::COORD_W-1:0] in_pos_x,
  input  logic signed [mln_pkg::COORD_W-1:0] in_pos_y,
  input  logic signed [mln_pkg::COORD_W-1:0] in_pos_z,
  mln_out_if.source                        out_ch
);
  import mln_pkg::*;

  op_t                       op_r;
  logic signed [COORD_W-1:0] pt_r   [3];
  logic signed [COORD_W-1:0] lo_r   [3];
  logic signed [COORD_W-1:0] hi_r   [3];
  logic [CNT_W-1:0]          count_r;
  logic                      built_r;
  logic [IDX_W-1:0]          i_r;
  logic [IDX_W-1:0]          j_r;
  logic [1:0]                axis_r;
  logic [AXIS_BITS-1:0]      nrm_r  [3];
  logic [CODE_W-1:0]         code_r;
  logic [CNT_W-1:0]          s_lo_r;
  logic [CNT_W-1:0]          s_hx_r;
  logic [IDX_W-1:0]          mid_r;
  logic [CODE_W-1:0]         pc_dist_r;
  logic [IDX_W-1:0]          pc_idx_r;
  logic                      pc_eq_r;
  logic                      pc_lt_r;
  logic [CODE_W-1:0]         best_dist_r;
  logic [IDX_W-1:0]          best_idx_r;
  logic                      found_r;
  status_t                   res_status_r;
  logic                      res_query_r;
  logic                      out_valid_r;
  logic [IDX_W-1:0]          out_idx_r;
  logic                      out_exact_r;
  logic [CODE_W-1:0]         out_code_r;
  status_t                   out_status_r;

  logic [COORD_W-1:0]        rd_x, rd_y, rd_z;
  logic [CODE_W-1:0]         crd_code;
  logic [IDX_W-1:0]          crd_idx;
  logic [IDX_W-1:0]          crd_addr;
  logic [IDX_W-1:0]          mid_c;
  logic [CNT_W-1:0]          span_c;
  logic                      tbl_wr;
  logic signed [COORD_W-1:0] n_p, n_lo, n_hi;
  logic                      n_done;
  logic [AXIS_BITS-1:0]      n_q;
  logic                      cnt_full;
  logic                      last_i;
  logic                      out_free;
  logic [CODE_W-1:0]         crd_dist;

  function automatic logic [CODE_W-1:0] absdiff(input logic [CODE_W-1:0] a,
                                               input logic [CODE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  assign cnt_full = count_r == CNT_W'(MAX_POINTS);
  assign last_i   = (CNT_W'(i_r) + CNT_W'(1)) == count_r;
  assign out_free = !out_valid_r || out_ch.ready;
  assign span_c   = s_hx_r - s_lo_r - CNT_W'(1);
  assign mid_c    = s_lo_r[IDX_W-1:0] + IDX_W'(span_c >> 1);
  assign crd_dist = absdiff(crd_code, code_r);

  always_comb begin
    unique case (cmd.crd_sel)
      CRD_PREV:  crd_addr = j_r - IDX_W'(1);
      CRD_FIRST: crd_addr = '0;
      CRD_MID:   crd_addr = mid_c;
      default:   crd_addr = '0;
    endcase
  end

  // point store, indexed by load order
  mln_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_mem_x (
    .clk, .wr_en(cmd.do_load), .wr_addr(count_r[IDX_W-1:0]), .wr_data(pt_r[0]),
    .rd_addr(i_r), .rd_data(rd_x));
  mln_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_mem_y (
    .clk, .wr_en(cmd.do_load), .wr_addr(count_r[IDX_W-1:0]), .wr_data(pt_r[1]),
    .rd_addr(i_r), .rd_data(rd_y));
  mln_ram #(.WIDTH(COORD_W), .DEPTH(MAX_POINTS)) u_mem_z (
    .clk, .wr_en(cmd.do_load), .wr_addr(count_r[IDX_W-1:0]), .wr_data(pt_r[2]),
    .rd_addr(i_r), .rd_data(rd_z));

  // sorted table
  assign tbl_wr = cmd.ins_shift || cmd.ins_put;

  mln_ram #(.WIDTH(CODE_W), .DEPTH(MAX_POINTS)) u_mem_code (
    .clk, .wr_en(tbl_wr), .wr_addr(j_r),
    .wr_data(cmd.ins_shift ? crd_code : code_r),
    .rd_addr(crd_addr), .rd_data(crd_code));
  mln_ram #(.WIDTH(IDX_W), .DEPTH(MAX_POINTS)) u_mem_idx (
    .clk, .wr_en(tbl_wr), .wr_addr(j_r),
    .wr_data(cmd.ins_shift ? crd_idx : i_r),
    .rd_addr(crd_addr), .rd_data(crd_idx));

  always_comb begin
    unique case (axis_r)
      AX_X:    begin n_p = pt_r[0]; n_lo = lo_r[0]; n_hi = hi_r[0]; end
      AX_Y:    begin n_p = pt_r[1]; n_lo = lo_r[1]; n_hi = hi_r[1]; end
      AX_Z:    begin n_p = pt_r[2]; n_lo = lo_r[2]; n_hi = hi_r[2]; end
      default: begin n_p = pt_r[0]; n_lo = lo_r[0]; n_hi = hi_r[0]; end
    endcase
  end

  mln_norm u_norm (
    .clk, .rst_n, .start(cmd.norm_start), .p(n_p), .low(n_lo), .high(n_hi),
    .done(n_done), .q(n_q));

  // control-side state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
      s_lo_r      <= '0;
      s_hx_r      <= '0;
      for (int a = 0; a < 3; a++) begin
        lo_r[a] <= '0;
        hi_r[a] <= '0;
      end
    end else begin
      if (cmd.do_clear) begin
        count_r <= '0;
        built_r <= 1'b0;
        for (int a = 0; a < 3; a++) begin
          lo_r[a] <= '0;
          hi_r[a] <= '0;
        end
      end
      if (cmd.do_load) begin
        // first point sets the box outright
        for (int a = 0; a < 3; a++) begin
          if (count_r == '0 || pt_r[a] < lo_r[a]) lo_r[a] <= pt_r[a];
          if (count_r == '0 || pt_r[a] > hi_r[a]) hi_r[a] <= pt_r[a];
        end
        count_r <= count_r + CNT_W'(1);
        built_r <= 1'b0;
      end
      if (cmd.ins_put && last_i) built_r <= 1'b1;
      if (cmd.q_init) begin
        s_lo_r <= '0;
        s_hx_r <= count_r;
      end
      if (cmd.q_upd && !pc_eq_r) begin
        if (pc_lt_r) s_lo_r <= CNT_W'(mid_r) + CNT_W'(1);
        else         s_hx_r <= CNT_W'(mid_r);
      end
      if (cmd.out_load)        out_valid_r <= 1'b1;
      else if (out_ch.ready)   out_valid_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= op_t'(in_op);
      pt_r[0] <= in_pos_x;
      pt_r[1] <= in_pos_y;
      pt_r[2] <= in_pos_z;
    end
    if (cmd.pt_latch) begin
      pt_r[0] <= rd_x;
      pt_r[1] <= rd_y;
      pt_r[2] <= rd_z;
    end
    if (cmd.i_clr)   i_r <= '0;
    if (cmd.ins_put) i_r <= i_r + IDX_W'(1);
    if (cmd.axis_clr) axis_r <= AX_X;
    if (cmd.norm_store) begin
      nrm_r[axis_r] <= n_q;
      axis_r        <= axis_r + 2'd1;
    end
    if (cmd.code_load) begin
      code_r <= interleave(nrm_r[0], nrm_r[1], nrm_r[2]);
      j_r    <= i_r;
    end
    if (cmd.ins_shift) j_r <= j_r - IDX_W'(1);
    if (cmd.q_init)  found_r <= 1'b0;
    if (cmd.q_first) begin
      best_idx_r  <= crd_idx;
      best_dist_r <= crd_dist;
    end
    if (cmd.q_probe) mid_r <= mid_c;
    if (cmd.q_cmp) begin
      pc_dist_r <= crd_dist;
      pc_idx_r  <= crd_idx;
      pc_eq_r   <= crd_code == code_r;
      pc_lt_r   <= crd_code < code_r;
    end
    if (cmd.q_upd) begin
      // an exact hit wins; otherwise strictly closer replaces
      if (pc_eq_r) begin
        best_idx_r <= pc_idx_r;
        found_r    <= 1'b1;
      end else if (pc_dist_r < best_dist_r) begin
        best_dist_r <= pc_dist_r;
        best_idx_r  <= pc_idx_r;
      end
    end
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_query_r  <= cmd.res_query;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_idx_r    <= res_query_r ? best_idx_r : '0;
      out_exact_r  <= res_query_r ? found_r : 1'b0;
      out_code_r   <= res_query_r ? code_r : '0;
    end
  end

  always_comb begin
    sts.op         = op_r;
    sts.cnt_zero   = count_r == '0;
    sts.cnt_full   = cnt_full;
    sts.built      = built_r;
    sts.norm_done  = n_done;
    sts.axis_last  = axis_r == AX_Z;
    sts.j_zero     = j_r == '0;
    sts.shift_need = crd_code > code_r;
    sts.last_i     = last_i;
    sts.search_end = s_lo_r >= s_hx_r;
    sts.probe_eq   = pc_eq_r;
    sts.out_free   = out_free;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.nearest_index = out_idx_r;
  assign out_ch.exact_match   = out_exact_r;
  assign out_ch.query_code    = out_code_r;
  assign out_ch.status        = out_status_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS))
    else $error("point count beyond table size");

  a_built_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    built_r |-> count_r != '0)
    else $error("table marked built with no points");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    s_lo_r <= s_hx_r)
    else $error("search window inverted");

  a_last_put_builds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_put && last_i |=> built_r)
    else $error("last insertion did not mark table built");
endmodule

/* design/mln_ctrl.sv */
// ----------------------------------------------------------------------------
// mln_ctrl
// Controller: decodes each command and sequences build, query and output.
// ----------------------------------------------------------------------------
module mln_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  mln_pkg::sts_t sts,
  output mln_pkg::cmd_t cmd,
  input  logic          in_valid,
  output logic          in_ready
);
  import mln_pkg::*;

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_FINISH;
        unique case (sts.op)
          OP_CLEAR: cmd.do_clear = 1'b1;
          OP_LOAD: begin
            if (sts.cnt_full) cmd.res_status = ST_FULL;
            else              cmd.do_load    = 1'b1;
          end
          OP_BUILD: begin
            if (sts.cnt_zero) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.set_res = 1'b0;
              cmd.i_clr   = 1'b1;
              state_nxt   = S_B_RD;
            end
          end
          OP_QUERY: begin
            if (!sts.built || sts.cnt_zero) begin
              cmd.res_status = ST_EMPTY;
            end else begin
              cmd.set_res  = 1'b0;
              cmd.axis_clr = 1'b1;
              state_nxt    = S_N_START;
            end
          end
          default: ;
        endcase
      end
      S_B_RD: state_nxt = S_B_LATCH;
      S_B_LATCH: begin
        cmd.pt_latch = 1'b1;
        cmd.axis_clr = 1'b1;
        state_nxt    = S_N_START;
      end
      S_N_START: begin
        cmd.norm_start = 1'b1;
        state_nxt      = S_N_WAIT;
      end
      S_N_WAIT: begin
        if (sts.norm_done) begin
          cmd.norm_store = 1'b1;
          state_nxt      = sts.axis_last ? S_CODE : S_N_START;
        end
      end
      S_CODE: begin
        cmd.code_load = 1'b1;
        state_nxt     = (sts.op == OP_QUERY) ? S_Q_INIT : S_I_CHK;
      end
      S_I_CHK: begin
        if (sts.j_zero) begin
          state_nxt = S_I_PUT;
        end else begin
          cmd.crd_sel = CRD_PREV;
          state_nxt   = S_I_CMP;
        end
      end
      S_I_CMP: begin
        // move the larger neighbor up one slot
        if (sts.shift_need) begin
          cmd.ins_shift = 1'b1;
          state_nxt     = S_I_CHK;
        end else begin
          state_nxt = S_I_PUT;
        end
      end
      S_I_PUT: begin
        cmd.ins_put = 1'b1;
        if (sts.last_i) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_FINISH;
        end else begin
          state_nxt = S_B_RD;
        end
      end
      S_Q_INIT: begin
        cmd.q_init  = 1'b1;
        cmd.crd_sel = CRD_FIRST;
        state_nxt   = S_Q_FIRST;
      end
      S_Q_FIRST: begin
        cmd.q_first = 1'b1;
        state_nxt   = S_Q_RD;
      end
      S_Q_RD: begin
        if (sts.search_end) begin
          state_nxt = S_Q_END;
        end else begin
          cmd.crd_sel = CRD_MID;
          cmd.q_probe = 1'b1;
          state_nxt   = S_Q_CMP;
        end
      end
      S_Q_CMP: begin
        cmd.q_cmp = 1'b1;
        state_nxt = S_Q_UPD;
      end
      S_Q_UPD: begin
        cmd.q_upd = 1'b1;
        state_nxt = sts.probe_eq ? S_Q_END : S_Q_RD;
      end
      S_Q_END: begin
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        cmd.res_query  = 1'b1;
        state_nxt      = S_FINISH;
      end
      S_FINISH: begin
        // hold until the output register is free
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

/* design/morton_sorted_nearest_lookup.sv */
// ----------------------------------------------------------------------------
// morton_sorted_nearest_lookup
// Loads 3D points, sorts them by Morton code and answers nearest lookups.
// ----------------------------------------------------------------------------
// Usage: in_ch carries one command per transaction (clear, load, build,
// query) with a Q16.16 point; out_ch returns exactly one result per command.
// Commands are handled one at a time; in_ch.ready is high only while the
// controller is idle.
// Steps, accept to out_ch.valid: clear and load pass through decode and finish
// only. Each point normalization runs three serial divider passes (one
// quotient bit per cycle; the quotient loop is skipped when the axis is
// clamped or zero), so a query runs the normalization and then one
// binary-search probe after another into the sorted table memory. A build
// normalizes each point for its code and then moves table entries one by
// one for the insertion sort.
// Reset empties the table and the bounding box; the memories are not
// cleared since entries are only read below the point count.
// A finished result waits in the output register while out_ch.ready is low;
// the next command is accepted meanwhile, but its result holds until the
// register is taken.
// ----------------------------------------------------------------------------
module morton_sorted_nearest_lookup (
  input  logic       clk,
  input  logic       rst_n,
  mln_in_if.sink     in_ch,
  mln_out_if.source  out_ch
);
  import mln_pkg::*;

  cmd_t cmd;
  sts_t sts;

  mln_ctrl u_ctrl (
    .clk, .rst_n, .sts, .cmd,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready));

  mln_dp u_dp (
    .clk, .rst_n, .cmd, .sts,
    .in_op(in_ch.op), .in_pos_x(in_ch.pos_x), .in_pos_y(in_ch.pos_y),
    .in_pos_z(in_ch.pos_z), .out_ch(out_ch));
endmodule

/* verif/morton_sorted_nearest_lookup_tb.sv */
// ----------------------------------------------------------------------------
// morton_sorted_nearest_lookup_tb
// Drives clear/load/build/query commands with random idle gaps on both
// channels and checks every result against a cycle-free predictor of the
// point table, its bounding box, the sorted Morton table and the search.
// ----------------------------------------------------------------------------
module morton_sorted_nearest_lookup_tb;
  import mln_pkg::*;

  typedef struct {
    logic [IDX_W-1:0]  idx;
    logic              exact;
    logic [CODE_W-1:0] code;
    status_t           st;
  } lookup_res_t;

  typedef struct {
    op_t         op;
    int          x;
    int          y;
    int          z;
    bit          fixed;
    lookup_res_t res;
  } cmd_row_t;

  logic clk;
  logic rst_n;
  int   err_cnt;
  int   res_cnt;

  mln_in_if  in_ch ();
  mln_out_if out_ch ();

  morton_sorted_nearest_lookup i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // predictor state
  int                pt_x [MAX_POINTS];
  int                pt_y [MAX_POINTS];
  int                pt_z [MAX_POINTS];
  logic [CODE_W-1:0] tbl_code [MAX_POINTS];
  logic [IDX_W-1:0]  tbl_idx [MAX_POINTS];
  int                box_lo [3];
  int                box_hi [3];
  int                n_pts;
  bit                table_ready;

  lookup_res_t pending_results [$];
  cmd_row_t    dir_rows [$];

  always #6 clk = ~clk;

  initial begin
    #50000000;
    $display("morton_sorted_nearest_lookup verification failed");
    $finish;
  end

  function automatic logic [AXIS_BITS-1:0] norm_axis(int p, int a);
    longint d;
    longint span;
    longint q;
    d    = longint'(p) - longint'(box_lo[a]);
    span = longint'(box_hi[a]) - longint'(box_lo[a]);
    if (span <= 0 || d <= 0) return '0;
    q = (d <<< AXIS_BITS) / span;
    if (q > longint'(NORM_TOP)) return NORM_TOP;
    return q[AXIS_BITS-1:0];
  endfunction

  function automatic logic [CODE_W-1:0] morton_of(int x, int y, int z);
    logic [AXIS_BITS-1:0] nx;
    logic [AXIS_BITS-1:0] ny;
    logic [AXIS_BITS-1:0] nz;
    logic [CODE_W-1:0]    c;
    nx = norm_axis(x, 0);
    ny = norm_axis(y, 1);
    nz = norm_axis(z, 2);
    for (int k = 0; k < AXIS_BITS; k++) begin
      c[3*k+2] = nx[k];
      c[3*k+1] = ny[k];
      c[3*k]   = nz[k];
    end
    return c;
  endfunction

  function automatic longint unsigned code_gap(logic [CODE_W-1:0] a, logic [CODE_W-1:0] b);
    return (a > b) ? longint'(a - b) : longint'(b - a);
  endfunction

  function automatic lookup_res_t apply_cmd(op_t op, int x, int y, int z);
    lookup_res_t       r;
    int                p [3];
    int                j;
    int                lo;
    int                hi;
    int                mid;
    logic [CODE_W-1:0] c;
    logic [CODE_W-1:0] best;
    r = '{idx: '0, exact: 1'b0, code: '0, st: ST_OK};
    p[0] = x;
    p[1] = y;
    p[2] = z;
    case (op)
      OP_CLEAR: begin
        for (int a = 0; a < 3; a++) begin
          box_lo[a] = 0;
          box_hi[a] = 0;
        end
        n_pts       = 0;
        table_ready = 0;
      end
      OP_LOAD: begin
        if (n_pts >= MAX_POINTS) begin
          r.st = ST_FULL;
        end else begin
          pt_x[n_pts] = x;
          pt_y[n_pts] = y;
          pt_z[n_pts] = z;
          for (int a = 0; a < 3; a++) begin
            if (n_pts == 0 || p[a] < box_lo[a]) box_lo[a] = p[a];
            if (n_pts == 0 || p[a] > box_hi[a]) box_hi[a] = p[a];
          end
          n_pts++;
          table_ready = 0;
        end
      end
      OP_BUILD: begin
        if (n_pts == 0) begin
          r.st = ST_EMPTY;
        end else begin
          for (int i = 0; i < n_pts; i++) begin
            c = morton_of(pt_x[i], pt_y[i], pt_z[i]);
            j = i;
            // shift larger codes up; equal codes stay in load order
            while (j > 0 && tbl_code[j-1] > c) begin
              tbl_code[j] = tbl_code[j-1];
              tbl_idx[j]  = tbl_idx[j-1];
              j--;
            end
            tbl_code[j] = c;
            tbl_idx[j]  = i[IDX_W-1:0];
          end
          table_ready = 1;
        end
      end
      default: begin
        if (!table_ready || n_pts == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.code = morton_of(x, y, z);
          lo     = 0;
          hi     = n_pts - 1;
          best   = tbl_code[0];
          r.idx  = tbl_idx[0];
          while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            c   = tbl_code[mid];
            if (code_gap(c, r.code) < code_gap(best, r.code)) begin
              best  = c;
              r.idx = tbl_idx[mid];
            end
            if (c == r.code) begin
              r.idx   = tbl_idx[mid];
              r.exact = 1'b1;
              break;
            end else if (c < r.code) begin
              lo = mid + 1;
            end else begin
              hi = mid - 1;
            end
          end
        end
      end
    endcase
    return r;
  endfunction

  // hold valid through back-to-back transactions; drop it only for a gap
  task automatic send_cmd(op_t op, int x, int y, int z, bit fixed, lookup_res_t fx);
    int          gap;
    lookup_res_t r;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.op    = op;
    in_ch.pos_x = x;
    in_ch.pos_y = y;
    in_ch.pos_z = z;
    do @(posedge clk); while (!in_ch.ready);
    r = apply_cmd(op, x, y, z);
    pending_results.push_back(fixed ? fx : r);
  endtask

  task automatic row(op_t op, int x, int y, int z, bit fixed = 0,
                     logic [IDX_W-1:0] idx = '0, logic ex = 1'b0,
                     logic [CODE_W-1:0] code = '0, status_t st = ST_OK);
    cmd_row_t t;
    t.op    = op;
    t.x     = x;
    t.y     = y;
    t.z     = z;
    t.fixed = fixed;
    t.res   = '{idx: idx, exact: ex, code: code, st: st};
    dir_rows.push_back(t);
  endtask

  function automatic int rand_coord(int mode, int base);
    case (mode)
      0:       return $urandom;
      1:       return base + $signed($urandom_range(0, 4000)) - 2000;
      2:       return ($urandom_range(0, 1) == 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return base + $signed($urandom_range(0, 65536 * 64)) - 65536 * 32;
    endcase
  endfunction

  // result side: random stalls, one long hold-off to back up the block
  initial begin
    lookup_res_t exp_r;
    int          stall;
    out_ch.ready = 1'b0;
    res_cnt      = 0;
    @(posedge rst_n);
    forever begin
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
      if (res_cnt == 40) stall = 400;
      if (stall > 0) begin
        @(negedge clk);
        out_ch.ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      res_cnt++;
      if (pending_results.size() == 0) begin
        $error("result with no command outstanding");
        err_cnt++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_ch.nearest_index !== exp_r.idx) begin
          $error("nearest_index exp %0d got %0d", exp_r.idx, out_ch.nearest_index);
          err_cnt++;
        end
        if (out_ch.exact_match !== exp_r.exact) begin
          $error("exact_match exp %0d got %0d", exp_r.exact, out_ch.exact_match);
          err_cnt++;
        end
        if (out_ch.query_code !== exp_r.code) begin
          $error("query_code exp %h got %h", exp_r.code, out_ch.query_code);
          err_cnt++;
        end
        if (out_ch.status !== exp_r.st) begin
          $error("status exp %0d got %0d", exp_r.st, out_ch.status);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    lookup_res_t none;
    int          n_cmds;
    int          n_load;
    int          n_q;
    int          mode;
    int          bx;
    int          by;
    int          bz;
    int          k;
    op_t         op;
    bit          filled;
    clk         = 1'b0;
    rst_n       = 1'b0;
    err_cnt     = 0;
    filled      = 0;
    in_ch.valid = 1'b0;
    in_ch.op    = OP_CLEAR;
    in_ch.pos_x = 0;
    in_ch.pos_y = 0;
    in_ch.pos_z = 0;
    none        = '{idx: '0, exact: 1'b0, code: '0, st: ST_OK};
    void'(apply_cmd(OP_CLEAR, 0, 0, 0));
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    row(OP_QUERY, 1, 2, 3, 1, 0, 0, 0, ST_EMPTY);
    row(OP_BUILD, 0, 0, 0, 1, 0, 0, 0, ST_EMPTY);
    row(OP_LOAD, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1);
    row(OP_LOAD, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1);
    row(OP_LOAD, 0, 0, 0, 1);
    row(OP_QUERY, 0, 0, 0, 1, 0, 0, 0, ST_EMPTY);
    row(OP_LOAD, 0, 0, 0, 1);
    row(OP_BUILD, 0, 0, 0, 1);
    row(OP_QUERY, 32'sh80000000, 32'sh80000000, 32'sh80000000, 1, 1, 1, 0, ST_OK);
    row(OP_QUERY, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1, 0, 1, '1, ST_OK);
    row(OP_QUERY, 0, 0, 0);
    row(OP_QUERY, 32'sh7fffffff, 32'sh80000000, 5);
    row(OP_QUERY, -1, 65536, 32'sh80000001);
    row(OP_BUILD, 0, 0, 0, 1);
    row(OP_CLEAR, 0, 0, 0, 1);
    row(OP_QUERY, 7, 7, 7, 1, 0, 0, 0, ST_EMPTY);
    // a single point: every axis has zero span, so every code is zero
    row(OP_LOAD, 5, 5, 5, 1);
    row(OP_BUILD, 0, 0, 0, 1);
    row(OP_QUERY, 100, -3, 7, 1, 0, 1, 0, ST_OK);
    row(OP_LOAD, 5, 9, -9);
    row(OP_QUERY, 5, 5, 5, 1, 0, 0, 0, ST_EMPTY);
    row(OP_BUILD, 0, 0, 0);
    row(OP_QUERY, 5, 9, 0);
    foreach (dir_rows[i])
      send_cmd(dir_rows[i].op, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
               dir_rows[i].fixed, dir_rows[i].res);

    n_cmds = 0;
    while (n_cmds < 950) begin
      // fill the table once to reach the full status
      if (!filled) begin
        filled = 1;
        send_cmd(OP_CLEAR, 0, 0, 0, 0, none);
        for (int i = 0; i <= MAX_POINTS; i++)
          send_cmd(OP_LOAD, $urandom, $urandom, $urandom, 0, none);
        send_cmd(OP_QUERY, 1, 1, 1, 0, none);
        n_cmds += MAX_POINTS + 3;
      end
      send_cmd(OP_CLEAR, 0, 0, 0, 0, none);
      mode   = $urandom_range(0, 3);
      bx     = $urandom;
      by     = $urandom;
      bz     = $urandom;
      n_load = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      for (int i = 0; i < n_load; i++) begin
        if (i > 0 && $urandom_range(0, 5) == 0) begin
          k = $urandom_range(0, i - 1);
          send_cmd(OP_LOAD, pt_x[k], pt_y[k], pt_z[k], 0, none);
        end else begin
          send_cmd(OP_LOAD, rand_coord(mode, bx), rand_coord(mode, by),
                   rand_coord(mode, bz), 0, none);
        end
      end
      if ($urandom_range(0, 7) == 0) send_cmd(OP_QUERY, bx, by, bz, 0, none);
      send_cmd(OP_BUILD, 0, 0, 0, 0, none);
      n_q = $urandom_range(3, 10);
      for (int i = 0; i < n_q; i++) begin
        if (n_pts > 0 && $urandom_range(0, 1) == 1) begin
          k = $urandom_range(0, n_pts - 1);
          send_cmd(OP_QUERY, pt_x[k], pt_y[k], pt_z[k], 0, none);
        end else if ($urandom_range(0, 9) == 0) begin
          op = op_t'($urandom_range(0, 3));
          send_cmd(op, rand_coord(mode, bx), rand_coord(mode, by),
                   rand_coord(mode, bz), 0, none);
        end else begin
          send_cmd(OP_QUERY, rand_coord(mode, bx), rand_coord(mode, by),
                   rand_coord(mode, bz), 0, none);
        end
      end
      n_cmds += n_load + n_q + 2;
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0)
      $display("morton_sorted_nearest_lookup verification clean");
    else
      $display("morton_sorted_nearest_lookup verification failed");
    $finish;
  end

endmodule
